@@ rtl/pae_pkg.sv @@
// Shared types, constants and helper functions for the particle attraction pipeline.
package pae_pkg;

  localparam int unsigned DataW  = 32;  // Q16.16 word
  localparam int unsigned DiffW  = 33;  // exact offset pos - attractor
  localparam int unsigned PosW   = 6;   // leading-one position of a DiffW value
  localparam int unsigned NormW  = 20;  // normalized magnitude, max in [2^19, 2^20)
  localparam int unsigned NormTop = 19;
  localparam int unsigned SqW    = 2 * NormW;
  localparam int unsigned SumW   = SqW + 2;
  localparam int unsigned RadW   = SumW + 20;   // radicand S * 2^20
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned NumW   = NormW + 26 + 1;
  localparam int unsigned DivW   = NumW + 1;
  localparam int unsigned UnitW  = QuotW + 1;
  localparam int unsigned DtW    = 31;
  localparam int unsigned AddrW  = 5;
  localparam logic [QuotW-1:0] UnitOne = QuotW'(65536);
  localparam logic [DtW-1:0]   DtReset = DtW'(1092);

  typedef enum logic [2:0] {
    RegAttX     = 3'd0,
    RegAttY     = 3'd1,
    RegAttZ     = 3'd2,
    RegStrength = 3'd3,
    RegTimeStep = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_z;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
    logic signed [DataW-1:0] vel_z;
    logic                    last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] new_pos_x;
    logic signed [DataW-1:0] new_pos_y;
    logic signed [DataW-1:0] new_pos_z;
    logic signed [DataW-1:0] new_vel_x;
    logic signed [DataW-1:0] new_vel_y;
    logic signed [DataW-1:0] new_vel_z;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] att_x;
    logic signed [DataW-1:0] att_y;
    logic signed [DataW-1:0] att_z;
    logic signed [DataW-1:0] strength;
    logic [DtW-1:0]          time_step;
  } cfg_t;

  // Per-particle data that rides along the root and divide stages
  typedef struct packed {
    in_item_t              item;
    logic [2:0]            neg;
    logic                  zero;
    logic [2:0][NormW-1:0] mag;
  } side_t;

  // Round a Q32-fraction product to Q16.16, ties toward plus infinity
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s >>> 16;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage

@@ rtl/pae_stream_if.sv @@
// Valid/ready stream channel carrying one word of type T.
interface pae_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pae_norm.sv @@
// Offset, magnitude, block normalization and sum of squares (six stages).
module pae_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  pae_pkg::in_item_t          item_i,
  input  pae_pkg::cfg_t              cfg_i,
  output logic                       valid_o,
  output pae_pkg::side_t             side_o,
  output logic [pae_pkg::SumW-1:0]   sum_o
);

  localparam int unsigned DW = pae_pkg::DiffW;
  localparam int unsigned NW = pae_pkg::NormW;

  logic [5:0] v_q;

  // stage A
  pae_pkg::in_item_t       it_a_q;
  logic signed [DW-1:0]    d_a_q [3];
  // stage B
  pae_pkg::in_item_t       it_b_q;
  logic [2:0]              neg_b_q;
  logic [DW-1:0]           abs_b_q [3];
  logic [DW-1:0]           max_b_q;
  // stage C
  pae_pkg::in_item_t       it_c_q;
  logic [2:0]              neg_c_q;
  logic [DW-1:0]           abs_c_q [3];
  logic [pae_pkg::PosW-1:0] lead_c_q;
  logic                    zero_c_q;
  // stage D
  pae_pkg::side_t          sd_d_q;
  // stage E
  pae_pkg::side_t          sd_e_q;
  logic [pae_pkg::SqW-1:0] sq_e_q [3];
  // stage F
  pae_pkg::side_t          sd_f_q;
  logic [pae_pkg::SumW-1:0] sum_f_q;

  logic signed [DW-1:0]    pos_w [3];
  logic signed [DW-1:0]    att_w [3];
  logic signed [DW-1:0]    d_d  [3];
  logic [DW-1:0]           abs_d [3];
  logic [DW-1:0]           max_d;
  logic [pae_pkg::PosW-1:0] lead_d;
  logic [2:0][NW-1:0]      mag_d;

  assign pos_w[0] = DW'(item_i.pos_x);
  assign pos_w[1] = DW'(item_i.pos_y);
  assign pos_w[2] = DW'(item_i.pos_z);
  assign att_w[0] = DW'(cfg_i.att_x);
  assign att_w[1] = DW'(cfg_i.att_y);
  assign att_w[2] = DW'(cfg_i.att_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i]   = pos_w[i] - att_w[i];
      abs_d[i] = d_a_q[i][DW-1] ? DW'(-d_a_q[i]) : DW'(d_a_q[i]);
    end
    max_d = abs_d[0];
    if (abs_d[1] > max_d) max_d = abs_d[1];
    if (abs_d[2] > max_d) max_d = abs_d[2];
  end

  always_comb begin
    lead_d = '0;
    for (int b = 0; b < DW; b++) begin
      if (max_b_q[b]) lead_d = pae_pkg::PosW'(b);
    end
  end

  // bring the largest magnitude into [2^19, 2^20); right shift truncates
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead_c_q >= pae_pkg::PosW'(pae_pkg::NormTop)) begin
        mag_d[i] = NW'(abs_c_q[i] >> (lead_c_q - pae_pkg::PosW'(pae_pkg::NormTop)));
      end else begin
        mag_d[i] = NW'(abs_c_q[i] << (pae_pkg::PosW'(pae_pkg::NormTop) - lead_c_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_a_q <= item_i;
      for (int i = 0; i < 3; i++) d_a_q[i] <= d_d[i];

      it_b_q <= it_a_q;
      for (int i = 0; i < 3; i++) begin
        neg_b_q[i] <= d_a_q[i][DW-1];
        abs_b_q[i] <= abs_d[i];
      end
      max_b_q <= max_d;

      it_c_q   <= it_b_q;
      neg_c_q  <= neg_b_q;
      abs_c_q  <= abs_b_q;
      lead_c_q <= lead_d;
      zero_c_q <= (max_b_q == '0);

      sd_d_q.item <= it_c_q;
      sd_d_q.neg  <= neg_c_q;
      sd_d_q.zero <= zero_c_q;
      sd_d_q.mag  <= mag_d;

      sd_e_q <= sd_d_q;
      for (int i = 0; i < 3; i++) begin
        sq_e_q[i] <= sd_d_q.mag[i] * sd_d_q.mag[i];
      end

      sd_f_q  <= sd_e_q;
      sum_f_q <= pae_pkg::SumW'(sq_e_q[0]) + pae_pkg::SumW'(sq_e_q[1])
               + pae_pkg::SumW'(sq_e_q[2]);
    end
  end

  assign valid_o = v_q[5];
  assign side_o  = sd_f_q;
  assign sum_o   = sum_f_q;

endmodule

@@ rtl/pae_sqrt.sv @@
// Pipelined integer square root of sum * 2^20, one root bit per stage.
module pae_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  pae_pkg::side_t             side_i,
  input  logic [pae_pkg::SumW-1:0]   sum_i,
  output logic                       valid_o,
  output pae_pkg::side_t             side_o,
  output logic [pae_pkg::RootW-1:0]  root_o
);

  localparam int unsigned N  = pae_pkg::RootW;
  localparam int unsigned XW = pae_pkg::RadW;
  localparam int unsigned MW = pae_pkg::RemW;

  logic                 st_v    [N+1];
  pae_pkg::side_t       st_side [N+1];
  logic [XW-1:0]        st_x    [N+1];
  logic [MW-1:0]        st_rem  [N+1];
  logic [N-1:0]         st_root [N+1];

  assign st_v[0]    = valid_i;
  assign st_side[0] = side_i;
  assign st_x[0]    = {sum_i, 20'b0};
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [MW+1:0] cur;
    logic [MW+1:0] trial;
    logic          take;
    logic          v_q;
    pae_pkg::side_t side_q;
    logic [XW-1:0] x_q;
    logic [MW-1:0] rem_q;
    logic [N-1:0]  root_q;

    assign cur   = {st_rem[k], st_x[k][XW-1 -: 2]};
    assign trial = (MW+2)'({st_root[k], 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= st_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= st_side[k];
        x_q    <= st_x[k] << 2;
        rem_q  <= take ? MW'(cur - trial) : MW'(cur);
        root_q <= {st_root[k][N-2:0], take};
      end
    end

    assign st_v[k+1]    = v_q;
    assign st_side[k+1] = side_q;
    assign st_x[k+1]    = x_q;
    assign st_rem[k+1]  = rem_q;
    assign st_root[k+1] = root_q;
  end

  assign valid_o = st_v[N];
  assign side_o  = st_side[N];
  assign root_o  = st_root[N];

endmodule

@@ rtl/pae_div.sv @@
// Pipelined restoring divider: three lanes of (mag * 2^26 + root/2) / root.
module pae_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  pae_pkg::side_t                side_i,
  input  logic [pae_pkg::RootW-1:0]     root_i,
  output logic                          valid_o,
  output pae_pkg::side_t                side_o,
  output logic [2:0][pae_pkg::QuotW-1:0] quot_o
);

  localparam int unsigned Q  = pae_pkg::QuotW;
  localparam int unsigned DV = pae_pkg::DivW;

  logic                 st_v    [Q+1];
  pae_pkg::side_t       st_side [Q+1];
  logic [pae_pkg::RootW-1:0] st_len [Q+1];
  logic [2:0][DV-1:0]   st_rem  [Q+1];
  logic [2:0][Q-1:0]    st_q    [Q+1];

  // setup stage: rounded numerator
  logic                 v0_q;
  pae_pkg::side_t       side0_q;
  logic [pae_pkg::RootW-1:0] len0_q;
  logic [2:0][DV-1:0]   num0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side0_q <= side_i;
      len0_q  <= root_i;
      for (int i = 0; i < 3; i++) begin
        num0_q[i] <= DV'({side_i.mag[i], 26'b0}) + DV'(root_i >> 1);
      end
    end
  end

  assign st_v[0]    = v0_q;
  assign st_side[0] = side0_q;
  assign st_len[0]  = len0_q;
  assign st_rem[0]  = num0_q;
  assign st_q[0]    = '0;

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int unsigned Sh = Q - 1 - k;
    logic [DV-1:0]      dvs;
    logic [2:0][DV-1:0] rem_d;
    logic [2:0][Q-1:0]  q_d;
    logic               v_q;
    pae_pkg::side_t     side_q;
    logic [pae_pkg::RootW-1:0] len_q;
    logic [2:0][DV-1:0] rem_q;
    logic [2:0][Q-1:0]  q_q;

    assign dvs = DV'(st_len[k]) << Sh;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = st_rem[k][i];
        q_d[i]   = st_q[k][i];
        if (st_rem[k][i] >= dvs) begin
          rem_d[i]   = st_rem[k][i] - dvs;
          q_d[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= st_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= st_side[k];
        len_q  <= st_len[k];
        rem_q  <= rem_d;
        q_q    <= q_d;
      end
    end

    assign st_v[k+1]    = v_q;
    assign st_side[k+1] = side_q;
    assign st_len[k+1]  = len_q;
    assign st_rem[k+1]  = rem_q;
    assign st_q[k+1]    = q_q;
  end

  assign valid_o = st_v[Q];
  assign side_o  = st_side[Q];
  assign quot_o  = st_q[Q];

endmodule

@@ rtl/pae_update.sv @@
// Unit vector, force scaling and Euler update with saturation (six stages).
module pae_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  pae_pkg::side_t                 side_i,
  input  logic [2:0][pae_pkg::QuotW-1:0] quot_i,
  input  pae_pkg::cfg_t                  cfg_i,
  output logic                           valid_o,
  output pae_pkg::out_item_t             item_o
);

  localparam int unsigned UW = pae_pkg::UnitW;
  localparam int unsigned DW = pae_pkg::DataW;

  logic [5:0] v_q;

  pae_pkg::in_item_t       it_u_q, it_1_q, it_2_q, it_3_q, it_4_q;
  logic signed [UW-1:0]    u_q   [3];
  logic signed [UW+DW-1:0] p1_q  [3];
  logic signed [63:0]      p2_q  [3];
  logic signed [DW-1:0]    nv_q  [3];
  logic signed [DW-1:0]    nv4_q [3];
  logic signed [63:0]      p3_q  [3];
  pae_pkg::out_item_t      out_q;

  logic signed [DW-1:0]    vel_w [3];
  logic signed [DW-1:0]    pos_w [3];
  logic signed [DW-1:0]    dts;
  logic signed [UW-1:0]    u_d   [3];
  logic signed [DW+1:0]    f_d   [3];
  logic signed [DW-1:0]    nv_d  [3];
  logic signed [DW-1:0]    np_d  [3];
  logic [pae_pkg::QuotW-1:0] mag_d;

  assign dts = $signed({1'b0, cfg_i.time_step});

  assign vel_w[0] = it_2_q.vel_x;
  assign vel_w[1] = it_2_q.vel_y;
  assign vel_w[2] = it_2_q.vel_z;
  assign pos_w[0] = it_4_q.pos_x;
  assign pos_w[1] = it_4_q.pos_y;
  assign pos_w[2] = it_4_q.pos_z;

  always_comb begin
    mag_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d  = (quot_i[i] > pae_pkg::UnitOne) ? pae_pkg::UnitOne : quot_i[i];
      u_d[i] = side_i.zero ? '0
             : (side_i.neg[i] ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d}));
      f_d[i] = (DW+2)'(pae_pkg::rnd16(64'(p1_q[i])));
      nv_d[i] = pae_pkg::sat32(64'(vel_w[i]) - pae_pkg::rnd16(p2_q[i]));
      np_d[i] = pae_pkg::sat32(64'(pos_w[i]) + pae_pkg::rnd16(p3_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_u_q <= side_i.item;
      it_1_q <= it_u_q;
      it_2_q <= it_1_q;
      it_3_q <= it_2_q;
      it_4_q <= it_3_q;
      for (int i = 0; i < 3; i++) begin
        u_q[i]   <= u_d[i];
        p1_q[i]  <= u_q[i] * cfg_i.strength;
        p2_q[i]  <= 64'(f_d[i]) * 64'(dts);
        nv_q[i]  <= nv_d[i];
        nv4_q[i] <= nv_q[i];
        p3_q[i]  <= 64'(nv_q[i]) * 64'(dts);
      end
      out_q.new_pos_x <= np_d[0];
      out_q.new_pos_y <= np_d[1];
      out_q.new_pos_z <= np_d[2];
      out_q.new_vel_x <= nv4_q[0];
      out_q.new_vel_y <= nv4_q[1];
      out_q.new_vel_z <= nv4_q[2];
      out_q.last_out  <= it_4_q.last_particle;
    end
  end

  assign valid_o = v_q[5];
  assign item_o  = out_q;

  property p_unit_bounded(int i);
    @(posedge clk_i) disable iff (!rst_ni)
      v_q[0] |-> (u_q[i] <= $signed(UW'(65536))) && (u_q[i] >= -$signed(UW'(65536)));
  endproperty

  a_unit_x : assert property (p_unit_bounded(0)) else $error("unit x out of range");
  a_unit_y : assert property (p_unit_bounded(1)) else $error("unit y out of range");
  a_unit_z : assert property (p_unit_bounded(2)) else $error("unit z out of range");

endmodule

@@ rtl/particle_attract_euler_step.sv @@
// Top level: APB registers, particle pipeline and output skid stage.
// One particle word is taken per clock and one result word leaves per clock once the
// pipe is full, as long as the output is not stalled. The pipe is made of the
// bit-per-stage square root (31 stages) and the three-lane divider (18 stages) plus
// the normalize, multiply and output stages. When the output is stalled the pipe keeps
// advancing until the one-word skid buffer fills, then the input deasserts ready.
// Registers: attractor x/y/z at 0x0/0x4/0x8, strength at 0xC, time step at 0x10;
// write them only while no particle is in flight.
module particle_attract_euler_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pae_stream_if.sink                  in_i,
  pae_stream_if.source                out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pae_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  pae_pkg::cfg_t   cfg_q;
  pae_pkg::reg_idx_e reg_idx;
  logic            en;

  logic            nrm_v;
  pae_pkg::side_t  nrm_side;
  logic [pae_pkg::SumW-1:0] nrm_sum;
  logic            sq_v;
  pae_pkg::side_t  sq_side;
  logic [pae_pkg::RootW-1:0] sq_root;
  logic            dv_v;
  pae_pkg::side_t  dv_side;
  logic [2:0][pae_pkg::QuotW-1:0] dv_quot;
  logic            up_v;
  pae_pkg::out_item_t up_item;

  logic               out_v_q, skid_v_q;
  pae_pkg::out_item_t out_q, skid_q;
  logic               take;

  assign reg_idx = pae_pkg::reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.att_x     <= '0;
      cfg_q.att_y     <= '0;
      cfg_q.att_z     <= '0;
      cfg_q.strength  <= '0;
      cfg_q.time_step <= pae_pkg::DtReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pae_pkg::RegAttX:     cfg_q.att_x     <= pwdata;
        pae_pkg::RegAttY:     cfg_q.att_y     <= pwdata;
        pae_pkg::RegAttZ:     cfg_q.att_z     <= pwdata;
        pae_pkg::RegStrength: cfg_q.strength  <= pwdata;
        pae_pkg::RegTimeStep: cfg_q.time_step <= pwdata[pae_pkg::DtW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pae_pkg::RegAttX:     prdata = cfg_q.att_x;
      pae_pkg::RegAttY:     prdata = cfg_q.att_y;
      pae_pkg::RegAttZ:     prdata = cfg_q.att_z;
      pae_pkg::RegStrength: prdata = cfg_q.strength;
      pae_pkg::RegTimeStep: prdata = {1'b0, cfg_q.time_step};
      default:              prdata = '0;
    endcase
  end

  // whole pipe advances unless the skid word is occupied
  assign en       = !skid_v_q;
  assign in_i.ready = en;

  pae_norm u_norm (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_i.valid), .item_i(in_i.data), .cfg_i(cfg_q),
    .valid_o(nrm_v), .side_o(nrm_side), .sum_o(nrm_sum)
  );

  pae_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(nrm_v), .side_i(nrm_side), .sum_i(nrm_sum),
    .valid_o(sq_v), .side_o(sq_side), .root_o(sq_root)
  );

  pae_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sq_v), .side_i(sq_side), .root_i(sq_root),
    .valid_o(dv_v), .side_o(dv_side), .quot_o(dv_quot)
  );

  pae_update u_update (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(dv_v), .side_i(dv_side), .quot_i(dv_quot), .cfg_i(cfg_q),
    .valid_o(up_v), .item_o(up_item)
  );

  assign take = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      out_v_q  <= skid_v_q || up_v;
      skid_v_q <= 1'b0;
    end else if (en && up_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : up_item;
    end else if (en && up_v) begin
      skid_q <= up_item;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word held without output word");

  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_o.ready) |=> (skid_v_q && $stable(skid_q)))
    else $error("skid word lost under stall");

  a_skid_catches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready && !skid_v_q && up_v) |=> skid_v_q)
    else $error("pipe word dropped under stall");

endmodule
